/* hdl/selective_repeat_receiver_window_macros.svh */
// Assertion macros used by the receiver window RTL.
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define SRRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SRRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SRRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SRRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/srrw_pkg.sv */
// Shared types and constants of the selective-repeat receiver window.
package srrw_pkg;

  // Fixed field widths.
  localparam int SEQ_W   = 10;
  localparam int KIND_W  = 2;
  localparam int DATA_W  = 32;
  localparam int WSIZE_W = 6;
  localparam int RANGE_W = 11;
  localparam int CIDX_W  = 1;
  localparam int CDATA_W = 11;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_IDX_WINDOW = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_IDX_RANGE  = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_ACK  = 4'b0100,
    S_DLV  = 4'b1000
  } state_t;

  // Classification of an arriving packet against the window.
  typedef struct packed {
    logic ignore;
    logic reack;
    logic accept;
  } class_t;

endpackage

/* hdl/srrw_slot_ram.sv */
// Payload buffer: one write port and one registered read port.
module srrw_slot_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/srrw_window_calc.sv */
// Window arithmetic: effective range and window, offset and buffer slot of a packet.
module srrw_window_calc #(
  parameter int MAX_WINDOW    = 32,
  parameter int MAX_SEQ_RANGE = 1024,
  parameter int RW            = 11,
  parameter int IW            = 5
) (
  input  logic [srrw_pkg::SEQ_W-1:0]   seq_i,
  input  logic [RW-1:0]                base_i,
  input  logic [IW-1:0]                head_i,
  input  logic [srrw_pkg::WSIZE_W-1:0] wsize_i,
  input  logic [srrw_pkg::RANGE_W-1:0] range_i,
  output srrw_pkg::class_t             cls_o,
  output logic [IW-1:0]                phys_o,
  output logic [RW-1:0]                range_eff_o
);
  import srrw_pkg::*;

  localparam int PW = IW + 1;

  logic [RW-1:0] r_raw;
  logic [RW-1:0] r_eff;
  logic [RW-1:0] half;
  logic [RW-1:0] cap;
  logic [RW-1:0] ws;
  logic [RW-1:0] w_eff;
  logic [RW-1:0] seq;
  logic [RW-1:0] diff;
  logic [RW-1:0] d;
  logic          out_of_range;
  logic          in_win;
  logic          behind;
  logic [PW-1:0] sum;

  // Saturate the range and the window size.
  always_comb begin
    r_raw = RW'(range_i);
    if (r_raw < RW'(2)) begin
      r_eff = RW'(2);
    end else if (r_raw > RW'(MAX_SEQ_RANGE)) begin
      r_eff = RW'(MAX_SEQ_RANGE);
    end else begin
      r_eff = r_raw;
    end
    half = r_eff >> 1;
    cap  = (half < RW'(MAX_WINDOW)) ? half : RW'(MAX_WINDOW);
    ws   = RW'(wsize_i);
    if (ws == '0) begin
      w_eff = RW'(1);
    end else if (ws > cap) begin
      w_eff = cap;
    end else begin
      w_eff = ws;
    end
  end

  // Offset of the packet from the window base, modulo the range.
  always_comb begin
    seq          = RW'(seq_i);
    out_of_range = (seq >= r_eff);
    diff         = seq - base_i;
    d            = (seq >= base_i) ? diff : diff + r_eff;
    in_win       = (d < w_eff);
    behind       = (d >= r_eff - w_eff);
  end

  // Classify the packet.
  always_comb begin
    cls_o.accept = !out_of_range && in_win;
    cls_o.reack  = !out_of_range && !in_win && behind;
    cls_o.ignore = out_of_range || (!in_win && !behind);
  end

  // Circular buffer slot of the packet: head plus offset, wrapped once.
  always_comb begin
    sum = PW'(head_i) + PW'(d);
    if (sum >= PW'(MAX_WINDOW)) begin
      phys_o = IW'(sum - PW'(MAX_WINDOW));
    end else begin
      phys_o = IW'(sum);
    end
  end

  assign range_eff_o = r_eff;

endmodule

/* hdl/selective_repeat_receiver_window.sv */
// An accepted packet is evaluated, then its acknowledgement is loaded into the output register.
// Deliveries follow the acknowledgement at one per cycle while the output is free.
// A new packet is taken only in idle, after the evaluate, acknowledge and delivery steps of the
// last (an ignored one skips acknowledge and delivery); input after done is taken and dropped.
// Reset is synchronous: window, received marks and done flag clear at once,
// registers return to window 20 and range 80; the payload buffer is not cleared.
`include "selective_repeat_receiver_window_macros.svh"

module selective_repeat_receiver_window #(
  parameter int MAX_WINDOW    = 32,
  parameter int MAX_SEQ_RANGE = 1024,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input packets
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srrw_pkg::SEQ_W-1:0]   in_seq_num,
  input  logic [PAYLOAD_BITS-1:0]      in_payload,
  input  logic                         in_is_final,
  // Results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [srrw_pkg::KIND_W-1:0]  out_result_kind,
  output logic [srrw_pkg::SEQ_W-1:0]   out_result_seq,
  output logic [srrw_pkg::DATA_W-1:0]  out_result_data,
  output logic                         out_last,
  // Configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srrw_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [srrw_pkg::CDATA_W-1:0] cfg_data
);
  import srrw_pkg::*;

  localparam int RW = ($clog2(MAX_SEQ_RANGE + 1) > RANGE_W) ?
                      $clog2(MAX_SEQ_RANGE + 1) : RANGE_W;
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [SEQ_W-1:0]        seq_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    fin_r;
  logic [RW-1:0]           base_r;
  logic [IW-1:0]           head_r;
  logic [MAX_WINDOW-1:0]   rcv_r;
  logic                    done_r;
  logic [WSIZE_W-1:0]      wsize_r;
  logic [RANGE_W-1:0]      range_r;
  logic [KIND_W-1:0]       pend_kind_r;
  logic [SEQ_W-1:0]        pend_seq_r;
  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [SEQ_W-1:0]        out_seq_r;
  logic [DATA_W-1:0]       out_data_r;
  logic                    out_last_r;

  class_t                  cls;
  logic [IW-1:0]           phys;
  logic [RW-1:0]           range_eff;
  logic [IW-1:0]           head_inc;
  logic [RW-1:0]           base_inc;
  logic                    next_rcv;
  logic                    can_load;
  logic                    in_xfer;
  logic                    cfg_xfer;
  logic                    mem_we;
  logic [IW-1:0]           rd_addr;
  logic [PAYLOAD_BITS-1:0] rd_data;

  // Window arithmetic on the latched packet.
  srrw_window_calc #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_SEQ_RANGE(MAX_SEQ_RANGE),
    .RW           (RW),
    .IW           (IW)
  ) u_calc (
    .seq_i      (seq_r),
    .base_i     (base_r),
    .head_i     (head_r),
    .wsize_i    (wsize_r),
    .range_i    (range_r),
    .cls_o      (cls),
    .phys_o     (phys),
    .range_eff_o(range_eff)
  );

  // Payload buffer, indexed by circular slot.
  srrw_slot_ram #(
    .DEPTH(MAX_WINDOW),
    .WIDTH(PAYLOAD_BITS),
    .AW   (IW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(phys),
    .wr_data(pay_r),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign can_load  = !out_valid_r || !out_stall;

  // Slot and sequence number that follow the window base.
  assign head_inc = (head_r == IW'(MAX_WINDOW - 1)) ? '0 : head_r + 1'b1;
  assign base_inc = ((base_r + RW'(1)) == range_eff) ? '0 : base_r + RW'(1);
  assign next_rcv = rcv_r[head_inc] && (head_inc != head_r);

  // A new packet is stored only in a slot that holds nothing yet.
  assign mem_we = (state_r == S_EVAL) && !fin_r && cls.accept && !rcv_r[phys];

  // The read runs one slot ahead while deliveries stream out.
  assign rd_addr = ((state_r == S_DLV) && can_load) ? head_inc : head_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && !done_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = (fin_r || !cls.ignore) ? S_ACK : S_IDLE;
      end
      S_ACK: begin
        if (can_load) begin
          state_nxt = rcv_r[head_r] ? S_DLV : S_IDLE;
        end
      end
      S_DLV: begin
        if (can_load && !next_rcv) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the accepted packet.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      seq_r <= in_seq_num;
      pay_r <= in_payload;
      fin_r <= in_is_final;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_W'(20);
      range_r <= RANGE_W'(80);
    end else if (cfg_xfer) begin
      case (cfg_index)
        CFG_IDX_WINDOW: wsize_r <= cfg_data[WSIZE_W-1:0];
        CFG_IDX_RANGE:  range_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Window state: base, head slot, received marks and done flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      head_r <= '0;
      rcv_r  <= '0;
      done_r <= 1'b0;
    end else begin
      if ((state_r == S_EVAL) && fin_r) begin
        done_r <= 1'b1;
      end
      if ((state_r == S_EVAL) && !fin_r && cls.accept) begin
        rcv_r[phys] <= 1'b1;
      end
      if ((state_r == S_DLV) && can_load) begin
        rcv_r[head_r] <= 1'b0;
        head_r        <= head_inc;
        base_r        <= base_inc;
      end
      if (cfg_xfer && (cfg_index == CFG_IDX_RANGE)) begin
        base_r <= '0;
        rcv_r  <= '0;
      end
    end
  end

  // Result held between evaluation and the acknowledgement transfer.
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      pend_kind_r <= fin_r ? KIND_DONE : KIND_ACK;
      pend_seq_r  <= fin_r ? '0 : seq_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load && (state_r == S_ACK)) begin
      out_valid_r <= 1'b1;
    end else if (can_load && (state_r == S_DLV)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && (state_r == S_ACK)) begin
      out_kind_r <= pend_kind_r;
      out_seq_r  <= pend_seq_r;
      out_data_r <= '0;
      out_last_r <= !rcv_r[head_r];
    end else if (can_load && (state_r == S_DLV)) begin
      out_kind_r <= KIND_DELIVER;
      out_seq_r  <= SEQ_W'(base_r);
      out_data_r <= DATA_W'(rd_data);
      out_last_r <= !next_rcv;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_result_seq  = out_seq_r;
  assign out_result_data = out_data_r;
  assign out_last        = out_last_r;

  // Checks on the window bookkeeping.
  `SRRW_ASSERT_IMP(a_idle_head_empty, clk, rst_n, state_r == S_IDLE, !rcv_r[head_r], "slot at window base marked while idle")
  `SRRW_ASSERT_IMP(a_dlv_marked, clk, rst_n, state_r == S_DLV, rcv_r[head_r], "delivery from an unmarked slot")
  `SRRW_ASSERT_IMP(a_base_in_range, clk, rst_n, state_r == S_IDLE, base_r < range_eff, "window base outside the range")
  `SRRW_ASSERT_NXT(a_done_sticky, clk, rst_n, done_r, done_r, "done flag cleared without reset")
  `SRRW_ASSERT_NXT(a_done_no_eval, clk, rst_n, done_r && (state_r == S_IDLE), state_r != S_EVAL, "packet evaluated after done")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the selective-repeat receiver window.
module tb_top;
  import srrw_pkg::*;

  localparam int MAX_WIN       = 32;
  localparam int MAX_RANGE     = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1500000;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
    logic              last;
  } reply_t;

  // Kinds of off-pattern packets mixed into the random bursts.
  typedef enum int unsigned {
    NOISE_BEHIND,
    NOISE_BEYOND,
    NOISE_OUTSIDE,
    NOISE_DUP,
    NOISE_ANY
  } noise_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [SEQ_W-1:0]   in_seq_num;
  logic [DATA_W-1:0]  in_payload;
  logic               in_is_final;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  out_result_kind;
  logic [SEQ_W-1:0]   out_result_seq;
  logic [DATA_W-1:0]  out_result_data;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  // Mirror of the receiver state and its registers.
  logic [WSIZE_W-1:0] win_reg;
  logic [RANGE_W-1:0] range_reg;
  logic [SEQ_W-1:0]   base;
  logic [MAX_WIN-1:0] marked;
  logic [DATA_W-1:0]  held [MAX_WIN];
  bit                 done_flag;

  reply_t      pending_replies [$];
  reply_t      got;
  reply_t      want;
  int          errors = 0;
  int unsigned packets_sent = 0;
  int          cycle_count = 0;

  // Idle controls for both sides and the long receiver hold-off.
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;

  selective_repeat_receiver_window i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_seq_num      (in_seq_num),
    .in_payload      (in_payload),
    .in_is_final     (in_is_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_result_seq  (out_result_seq),
    .out_result_data (out_result_data),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (rx_idling && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transfer with the oldest pending reply.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_result_kind, out_result_seq, out_result_data, out_last};
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing pending: kind=%0d seq=%0d data=%h last=%b",
                 $time, got.kind, got.seq, got.data, got.last);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected kind=%0d seq=%0d data=%h last=%b",
                   $time, want.kind, want.seq, want.data, want.last);
          $display("%0t:           actual   kind=%0d seq=%0d data=%h last=%b",
                   $time, got.kind, got.seq, got.data, got.last);
          errors++;
        end
      end
    end
  end

  // Sequence range as the block uses it.
  function automatic int unsigned range_eff();
    int unsigned r;
    r = range_reg;
    if (r < 2) r = 2;
    if (r > MAX_RANGE) r = MAX_RANGE;
    return r;
  endfunction

  // Window size as the block uses it, capped at half the range.
  function automatic int unsigned window_eff(input int unsigned r);
    int unsigned w;
    int unsigned cap;
    w = win_reg;
    cap = (r / 2 < MAX_WIN) ? r / 2 : MAX_WIN;
    if (w < 1) w = 1;
    if (w > cap) w = cap;
    return w;
  endfunction

  // Work out the acks, deliveries or done that one accepted packet causes.
  task automatic compute_replies(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] pay,
                                 input logic fin);
    int unsigned r;
    int unsigned w;
    int unsigned d;
    int unsigned n;
    int unsigned i;
    reply_t cur;
    r = range_eff();
    w = window_eff(r);
    if (done_flag) return;
    if (fin) begin
      done_flag = 1'b1;
      pending_replies.push_back({KIND_DONE, SEQ_W'(0), DATA_W'(0), 1'b1});
      return;
    end
    if (seq >= r) return;
    if (base >= r) base = '0;
    d = (seq + r - base) % r;
    if (d >= w) begin
      // Behind the window: acknowledge again; beyond it: drop silently.
      if (d >= r - w) pending_replies.push_back({KIND_ACK, seq, DATA_W'(0), 1'b1});
      return;
    end
    cur = {KIND_ACK, seq, DATA_W'(0), 1'b0};
    n = 1;
    // A duplicate keeps the payload stored first.
    if (!marked[d]) begin
      marked[d] = 1'b1;
      held[d] = pay;
    end
    while (marked[0] && n < MAX_WIN + 1) begin
      pending_replies.push_back(cur);
      cur = {KIND_DELIVER, base, held[0], 1'b0};
      for (i = 0; i < MAX_WIN - 1; i++) held[i] = held[i + 1];
      held[MAX_WIN - 1] = '0;
      marked = marked >> 1;
      base = SEQ_W'((base + 1) % r);
      n++;
    end
    cur.last = 1'b1;
    pending_replies.push_back(cur);
  endtask

  // Offer one packet, with an optional gap first, and wait for its transfer.
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [DATA_W-1:0] pay,
                             input logic fin);
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seq_num <= seq;
    in_payload <= pay;
    in_is_final <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    compute_replies(seq, pay, fin);
    packets_sent++;
  endtask

  // Let every pending reply arrive and the block fall idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; keep_valid leaves valid high for a following write.
  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val,
                           input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_IDX_WINDOW) begin
      win_reg = val[WSIZE_W-1:0];
    end else begin
      range_reg = val[RANGE_W-1:0];
      base = '0;
      marked = '0;
    end
    if (!keep_valid) cfg_valid <= 1'b0;
  endtask

  // Write both registers once the block is idle; unused window bits are random.
  task automatic set_config(input logic [WSIZE_W-1:0] w_set, input logic [RANGE_W-1:0] r_set);
    logic [CDATA_W-1:0] wval;
    settle();
    wval = CDATA_W'($urandom);
    wval[WSIZE_W-1:0] = w_set;
    cfg_write(CFG_IDX_WINDOW, wval, 1'b1);
    cfg_write(CFG_IDX_RANGE, r_set, 1'b0);
  endtask

  // Pick an off-pattern sequence number relative to the current window.
  function automatic logic [SEQ_W-1:0] noise_seq(input int unsigned r, input int unsigned w,
                                                 input logic [SEQ_W-1:0] start,
                                                 input int unsigned k);
    int unsigned d;
    case (noise_t'($urandom_range(0, 4)))
      NOISE_BEHIND: return SEQ_W'((base + r - 1 - $urandom_range(0, w - 1)) % r);
      NOISE_BEYOND: begin
        d = (r > 2 * w) ? $urandom_range(w, r - w - 1) : 0;
        return SEQ_W'((base + d) % r);
      end
      NOISE_OUTSIDE: begin
        if (r < MAX_RANGE) return SEQ_W'($urandom_range(r, MAX_RANGE - 1));
        return SEQ_W'($urandom);
      end
      NOISE_DUP: return SEQ_W'((start + $urandom_range(0, k - 1)) % r);
      default: return SEQ_W'($urandom);
    endcase
  endfunction

  // Send k consecutive sequence numbers from the base in shuffled order, with noise.
  // With zero_last the base packet comes last and no noise is mixed in, so the
  // final packet releases the whole burst at once.
  task automatic send_burst(input int unsigned k, input bit zero_last);
    int unsigned offs [MAX_WIN];
    int unsigned r;
    int unsigned w;
    int unsigned i;
    int unsigned j;
    int unsigned t;
    int unsigned span;
    logic [SEQ_W-1:0] start;
    r = range_eff();
    w = window_eff(r);
    start = base;
    for (i = 0; i < k; i++) offs[i] = zero_last ? (i + 1) % k : i;
    span = zero_last ? k - 1 : k;
    for (i = span; i > 1; i--) begin
      j = $urandom_range(0, i - 1);
      t = offs[i - 1];
      offs[i - 1] = offs[j];
      offs[j] = t;
    end
    for (i = 0; i < k; i++) begin
      if (!zero_last && $urandom_range(0, 4) == 0)
        send_packet(noise_seq(r, w, start, k), $urandom, 1'b0);
      send_packet(SEQ_W'((start + offs[i]) % r), $urandom, 1'b0);
    end
  endtask

  // Random bursts under one register setting.
  task automatic run_phase(input logic [WSIZE_W-1:0] w_set, input logic [RANGE_W-1:0] r_set,
                           input int unsigned n, input bit full_first);
    int unsigned target;
    int unsigned w;
    bit first;
    set_config(w_set, r_set);
    target = packets_sent + n;
    first = full_first;
    while (packets_sent < target) begin
      w = window_eff(range_eff());
      send_burst(first ? w : $urandom_range(1, w), first);
      first = 1'b0;
    end
  endtask

  // Reset settings: window 20, range 80.
  task automatic test_directed();
    send_packet(10'd0, 32'h0000_0000, 1'b0);    // in order: ack and delivery
    send_packet(10'd2, 32'hFFFF_FFFF, 1'b0);    // out of order: buffered
    send_packet(10'd2, 32'h1234_5678, 1'b0);    // duplicate keeps the first payload
    send_packet(10'd1, 32'hA5A5_A5A5, 1'b0);    // fills the gap: two deliveries
    send_packet(10'd0, 32'h5A5A_5A5A, 1'b0);    // behind the base
    send_packet(10'd79, 32'hDEAD_BEEF, 1'b0);   // top of the range, behind
    send_packet(10'd22, 32'h0BAD_F00D, 1'b0);   // last slot of the window
    send_packet(10'd23, 32'h1111_1111, 1'b0);   // first number past the window
    send_packet(10'd50, 32'h2222_2222, 1'b0);   // far beyond the window
    send_packet(10'd62, 32'h3333_3333, 1'b0);   // one short of the behind region
    send_packet(10'd63, 32'h4444_4444, 1'b0);   // oldest number still behind
    send_packet(10'd80, 32'h5555_5555, 1'b0);   // first number outside the range
    send_packet(10'd1023, 32'hFFFF_FFFF, 1'b0); // largest number, outside
    send_packet(10'd3, 32'h8000_0001, 1'b0);    // base packet: ack and delivery
  endtask

  // Marks beyond a shrunken window survive; a range write clears the window.
  task automatic test_window_shrink();
    int i;
    set_config(6'd8, 11'd64);
    for (i = 1; i < 8; i++) send_packet(SEQ_W'(i), $urandom, 1'b0);
    settle();
    cfg_write(CFG_IDX_WINDOW, {5'b10101, 6'd2}, 1'b0);
    send_packet(10'd5, $urandom, 1'b0);
    send_packet(10'd0, 32'h0F0F_0F0F, 1'b0);
    send_packet(10'd9, $urandom, 1'b0);
    settle();
    cfg_write(CFG_IDX_RANGE, 11'd64, 1'b0);
    send_packet(10'd0, $urandom, 1'b0);
    send_packet(10'd63, $urandom, 1'b0);
  endtask

  // Random traffic across settings, the register extremes among them.
  task automatic test_random_settings();
    run_phase(6'd1, 11'd2, 40, 1'b0);
    run_phase(6'd32, 11'd1024, 80, 1'b1);
    run_phase(6'd0, 11'd0, 30, 1'b0);
    run_phase(6'd63, 11'd2047, 50, 1'b1);
    run_phase(6'd5, 11'd11, 40, 1'b0);
    run_phase(6'd13, 11'd37, 50, 1'b0);
  endtask

  // The receiver holds off while in-order packets keep coming.
  task automatic test_backpressure();
    int i;
    set_config(6'd16, 11'd40);
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 40; i++) send_packet(base, $urandom, 1'b0);
  endtask

  // Closing traffic without idling, then the final marker and ignored inputs.
  task automatic test_final_marker();
    int i;
    tx_idling = 1'b0;
    rx_idling <= 1'b0;
    run_phase(6'd20, 11'd80, 60, 1'b0);
    send_packet(SEQ_W'($urandom), $urandom, 1'b1);
    for (i = 0; i < 4; i++) send_packet(base, $urandom, 1'b0);
    send_packet(SEQ_W'($urandom), $urandom, 1'b1);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_seq_num <= '0;
    in_payload <= '0;
    in_is_final <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_IDX_WINDOW;
    cfg_data <= '0;
    win_reg = WSIZE_W'(20);
    range_reg = RANGE_W'(80);
    base = '0;
    marked = '0;
    done_flag = 1'b0;
    foreach (held[k]) held[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_window_shrink();
    test_random_settings();
    test_backpressure();
    test_final_marker();

    // Drain what is still in flight.
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
